// ===== hw/rtl/rsi_pkg.sv =====
`timescale 1ns / 1ps
package rsi_pkg;

   // Far limit code that disables the distance test
   localparam logic [30:0] FAR_UNLIMITED = 31'h7FFF_FFFF;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0]        sphere_radius;
      logic [30:0]        far_limit;
   } rsi_req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] hit_distance;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
   } rsi_rsp_type;

   // Clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] rsi_sat32(logic signed [66:0] v);
      logic [35:0] top;
      top = v[66:31];
      if (top == '0 || top == '1) begin
         return v[31:0];
      end
      return v[66] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

endpackage

// ===== hw/rtl/ray_sphere_intersection.sv =====
`timescale 1ns / 1ps
// Ray-sphere intersector, geometric test, fully pipelined.
// Pipe from request accept to response valid: two root extractors of 50 and 33
// stages, a 49-stage normal divider and 15 math stages.
// Throughput: one request per cycle; the whole pipe holds while a response waits.
// Reset: synchronous, clears all stage valid bits; data registers are not reset.
module ray_sphere_intersection
   import rsi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rsi_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsi_rsp_type rsp_data
);
   localparam int RAD_W    = 100;
   localparam int NN_W     = 66;
   localparam int LEN_W    = NN_W / 2;
   localparam int NUM_W    = 49;
   localparam int SIDE1_W  = 1 + 50 + 31 + 9 * 32;
   localparam int SIDE2_W  = 1 + 32 + 3 * 32 + 3 * 33;
   localparam int DSIDE0_W = 1 + 1 + 1 + 32 + 3 * 32;

   logic        adv;
   logic        rsp_valid_ff;
   rsi_rsp_type rsp_data_ff;
   rsi_rsp_type rsp_in;

   // advance everything when the output slot is free or being taken
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   logic signed [31:0] in_o [3];
   logic signed [31:0] in_d [3];
   logic signed [31:0] in_c [3];

   assign in_o[0] = req_data.origin_x;
   assign in_o[1] = req_data.origin_y;
   assign in_o[2] = req_data.origin_z;
   assign in_d[0] = req_data.dir_x;
   assign in_d[1] = req_data.dir_y;
   assign in_d[2] = req_data.dir_z;
   assign in_c[0] = req_data.center_x;
   assign in_c[1] = req_data.center_y;
   assign in_c[2] = req_data.center_z;

   // ---------------- stage 1: L = centre - origin, r^2
   logic               s1_vld_ff;
   logic signed [32:0] s1_l_in  [3];
   logic signed [32:0] s1_l_ff  [3];
   logic signed [31:0] s1_o_ff  [3];
   logic signed [31:0] s1_d_ff  [3];
   logic signed [31:0] s1_c_ff  [3];
   logic [61:0]        s1_r2_in;
   logic [61:0]        s1_r2_ff;
   logic [30:0]        s1_far_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_l_in[i] = $signed({in_c[i][31], in_c[i]}) - $signed({in_o[i][31], in_o[i]});
      end
   end
   assign s1_r2_in = {31'b0, req_data.sphere_radius} * {31'b0, req_data.sphere_radius};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_l_ff   <= s1_l_in;
         s1_o_ff   <= in_o;
         s1_d_ff   <= in_d;
         s1_c_ff   <= in_c;
         s1_r2_ff  <= s1_r2_in;
         s1_far_ff <= req_data.far_limit;
      end
   end

   // ---------------- stage 2: products L*d and L*L
   logic               s2_vld_ff;
   logic signed [64:0] s2_ld_in  [3];
   logic signed [64:0] s2_ld_ff  [3];
   logic signed [64:0] s2_lsq_in [3];
   logic [64:0]        s2_lsq_ff [3];
   logic signed [31:0] s2_o_ff   [3];
   logic signed [31:0] s2_d_ff   [3];
   logic signed [31:0] s2_c_ff   [3];
   logic [61:0]        s2_r2_ff;
   logic [30:0]        s2_far_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_ld_in[i]  = $signed({{32{s1_l_ff[i][32]}}, s1_l_ff[i]})
                      * $signed({{33{s1_d_ff[i][31]}}, s1_d_ff[i]});
         s2_lsq_in[i] = $signed({{32{s1_l_ff[i][32]}}, s1_l_ff[i]})
                      * $signed({{32{s1_l_ff[i][32]}}, s1_l_ff[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ld_ff <= s2_ld_in;
         for (int i = 0; i < 3; i++) begin
            s2_lsq_ff[i] <= s2_lsq_in[i];
         end
         s2_o_ff   <= s1_o_ff;
         s2_d_ff   <= s1_d_ff;
         s2_c_ff   <= s1_c_ff;
         s2_r2_ff  <= s1_r2_ff;
         s2_far_ff <= s1_far_ff;
      end
   end

   // ---------------- stage 3: sum into tca (Q32.32) and L.L
   logic               s3_vld_ff;
   logic signed [66:0] s3_tcaw_in;
   logic signed [66:0] s3_tcaw_ff;
   logic [65:0]        s3_ll_in;
   logic [65:0]        s3_ll_ff;
   logic signed [31:0] s3_o_ff [3];
   logic signed [31:0] s3_d_ff [3];
   logic signed [31:0] s3_c_ff [3];
   logic [61:0]        s3_r2_ff;
   logic [30:0]        s3_far_ff;

   assign s3_tcaw_in = $signed({{2{s2_ld_ff[0][64]}}, s2_ld_ff[0]})
                     + $signed({{2{s2_ld_ff[1][64]}}, s2_ld_ff[1]})
                     + $signed({{2{s2_ld_ff[2][64]}}, s2_ld_ff[2]});
   assign s3_ll_in   = {1'b0, s2_lsq_ff[0]} + {1'b0, s2_lsq_ff[1]} + {1'b0, s2_lsq_ff[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_tcaw_ff <= s3_tcaw_in;
         s3_ll_ff   <= s3_ll_in;
         s3_o_ff    <= s2_o_ff;
         s3_d_ff    <= s2_d_ff;
         s3_c_ff    <= s2_c_ff;
         s3_r2_ff   <= s2_r2_ff;
         s3_far_ff  <= s2_far_ff;
      end
   end

   // ---------------- stage 4: behind-origin test, partial products of tca^2
   logic               s4_vld_ff;
   logic               s4_miss_ff;
   logic [49:0]        s4_tca_in;
   logic [49:0]        s4_tca_ff;
   logic [49:0]        s4_hh_ff;
   logic [49:0]        s4_hl_ff;
   logic [49:0]        s4_lo_ff;
   logic [65:0]        s4_ll_ff;
   logic signed [31:0] s4_o_ff [3];
   logic signed [31:0] s4_d_ff [3];
   logic signed [31:0] s4_c_ff [3];
   logic [61:0]        s4_r2_ff;
   logic [30:0]        s4_far_ff;

   assign s4_tca_in = s3_tcaw_ff[65:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_miss_ff <= s3_tcaw_ff[66];
         s4_tca_ff  <= s4_tca_in;
         s4_hh_ff   <= {25'b0, s4_tca_in[49:25]} * {25'b0, s4_tca_in[49:25]};
         s4_hl_ff   <= {25'b0, s4_tca_in[49:25]} * {25'b0, s4_tca_in[24:0]};
         s4_lo_ff   <= {25'b0, s4_tca_in[24:0]} * {25'b0, s4_tca_in[24:0]};
         s4_ll_ff   <= s3_ll_ff;
         s4_o_ff    <= s3_o_ff;
         s4_d_ff    <= s3_d_ff;
         s4_c_ff    <= s3_c_ff;
         s4_r2_ff   <= s3_r2_ff;
         s4_far_ff  <= s3_far_ff;
      end
   end

   // ---------------- stage 5: combine tca^2
   logic               s5_vld_ff;
   logic               s5_miss_ff;
   logic [99:0]        s5_tsq_in;
   logic [99:0]        s5_tsq_ff;
   logic [49:0]        s5_tca_ff;
   logic [65:0]        s5_ll_ff;
   logic signed [31:0] s5_o_ff [3];
   logic signed [31:0] s5_d_ff [3];
   logic signed [31:0] s5_c_ff [3];
   logic [61:0]        s5_r2_ff;
   logic [30:0]        s5_far_ff;

   assign s5_tsq_in = {s4_hh_ff, 50'b0} + {24'b0, s4_hl_ff, 26'b0} + {50'b0, s4_lo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_miss_ff <= s4_miss_ff;
         s5_tsq_ff  <= s5_tsq_in;
         s5_tca_ff  <= s4_tca_ff;
         s5_ll_ff   <= s4_ll_ff;
         s5_o_ff    <= s4_o_ff;
         s5_d_ff    <= s4_d_ff;
         s5_c_ff    <= s4_c_ff;
         s5_r2_ff   <= s4_r2_ff;
         s5_far_ff  <= s4_far_ff;
      end
   end

   // ---------------- stage 6: r^2 - d2 = r^2 + tca^2 - L.L, miss when negative
   logic               s6_vld_ff;
   logic               s6_miss_ff;
   logic signed [101:0] s6_diff_in;
   logic [RAD_W-1:0]   s6_rad_ff;
   logic [49:0]        s6_tca_ff;
   logic signed [31:0] s6_o_ff [3];
   logic signed [31:0] s6_d_ff [3];
   logic signed [31:0] s6_c_ff [3];
   logic [30:0]        s6_far_ff;

   assign s6_diff_in = $signed({40'b0, s5_r2_ff}) + $signed({2'b0, s5_tsq_ff})
                     - $signed({36'b0, s5_ll_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_miss_ff <= s5_miss_ff | s6_diff_in[101];
         s6_rad_ff  <= s6_diff_in[RAD_W-1:0];
         s6_tca_ff  <= s5_tca_ff;
         s6_o_ff    <= s5_o_ff;
         s6_d_ff    <= s5_d_ff;
         s6_c_ff    <= s5_c_ff;
         s6_far_ff  <= s5_far_ff;
      end
   end

   // ---------------- half chord thc = floor(sqrt(r^2 - d2))
   logic               q1_vld;
   logic [RAD_W/2-1:0] q1_thc;
   logic [SIDE1_W-1:0] q1_side;
   logic               q1_miss;
   logic [49:0]        q1_tca;
   logic [30:0]        q1_far;
   logic signed [31:0] q1_o [3];
   logic signed [31:0] q1_d [3];
   logic signed [31:0] q1_c [3];

   rsi_sqrt #(
      .IN_W   (RAD_W),
      .SIDE_W (SIDE1_W)
   ) u_thc_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s6_vld_ff),
      .in_rad    (s6_rad_ff),
      .in_side   ({s6_miss_ff, s6_tca_ff, s6_far_ff,
                   s6_o_ff[0], s6_o_ff[1], s6_o_ff[2],
                   s6_d_ff[0], s6_d_ff[1], s6_d_ff[2],
                   s6_c_ff[0], s6_c_ff[1], s6_c_ff[2]}),
      .out_valid (q1_vld),
      .out_root  (q1_thc),
      .out_side  (q1_side)
   );

   assign {q1_miss, q1_tca, q1_far, q1_o[0], q1_o[1], q1_o[2],
           q1_d[0], q1_d[1], q1_d[2], q1_c[0], q1_c[1], q1_c[2]} = q1_side;

   // ---------------- stage 7: t0 = tca - thc, far limit test
   logic               s7_vld_ff;
   logic               s7_miss_ff;
   logic signed [50:0] s7_t0_in;
   logic signed [50:0] s7_t0_ff;
   logic               s7_far_miss;
   logic signed [31:0] s7_o_ff [3];
   logic signed [31:0] s7_d_ff [3];
   logic signed [31:0] s7_c_ff [3];

   assign s7_t0_in    = $signed({1'b0, q1_tca}) - $signed({1'b0, q1_thc});
   assign s7_far_miss = (q1_far != FAR_UNLIMITED) && (s7_t0_in > $signed({20'b0, q1_far}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s7_vld_ff <= q1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_miss_ff <= q1_miss | s7_far_miss;
         s7_t0_ff   <= s7_t0_in;
         s7_o_ff    <= q1_o;
         s7_d_ff    <= q1_d;
         s7_c_ff    <= q1_c;
      end
   end

   // ---------------- stage 8: partial products of t0*dir
   logic               s8_vld_ff;
   logic               s8_miss_ff;
   logic signed [56:0] s8_ph_in [3];
   logic signed [56:0] s8_ph_ff [3];
   logic signed [58:0] s8_pl_in [3];
   logic signed [58:0] s8_pl_ff [3];
   logic signed [50:0] s8_t0_ff;
   logic signed [31:0] s8_o_ff [3];
   logic signed [31:0] s8_c_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s8_ph_in[i] = $signed({{32{s7_t0_ff[50]}}, s7_t0_ff[50:26]})
                     * $signed({{25{s7_d_ff[i][31]}}, s7_d_ff[i]});
         s8_pl_in[i] = $signed({33'b0, s7_t0_ff[25:0]})
                     * $signed({{27{s7_d_ff[i][31]}}, s7_d_ff[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (adv) begin
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_miss_ff <= s7_miss_ff;
         s8_ph_ff   <= s8_ph_in;
         s8_pl_ff   <= s8_pl_in;
         s8_t0_ff   <= s7_t0_ff;
         s8_o_ff    <= s7_o_ff;
         s8_c_ff    <= s7_c_ff;
      end
   end

   // ---------------- stage 9: combine t0*dir
   logic               s9_vld_ff;
   logic               s9_miss_ff;
   logic signed [82:0] s9_prod_in [3];
   logic signed [82:0] s9_prod_ff [3];
   logic signed [50:0] s9_t0_ff;
   logic signed [31:0] s9_o_ff [3];
   logic signed [31:0] s9_c_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s9_prod_in[i] = $signed({s8_ph_ff[i], 26'b0})
                       + $signed({{24{s8_pl_ff[i][58]}}, s8_pl_ff[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else if (adv) begin
         s9_vld_ff <= s8_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_miss_ff <= s8_miss_ff;
         s9_prod_ff <= s9_prod_in;
         s9_t0_ff   <= s8_t0_ff;
         s9_o_ff    <= s8_o_ff;
         s9_c_ff    <= s8_c_ff;
      end
   end

   // ---------------- stage 10: hit point = origin + (t0*dir >> 16), saturate
   logic               s10_vld_ff;
   logic               s10_miss_ff;
   logic signed [66:0] s10_q_in [3];
   logic signed [31:0] s10_p_ff [3];
   logic signed [31:0] s10_t0s_ff;
   logic signed [31:0] s10_c_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s10_q_in[i] = $signed(s9_prod_ff[i][82:16])
                     + $signed({{35{s9_o_ff[i][31]}}, s9_o_ff[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_vld_ff <= 1'b0;
      end else if (adv) begin
         s10_vld_ff <= s9_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s10_miss_ff <= s9_miss_ff;
         for (int i = 0; i < 3; i++) begin
            s10_p_ff[i] <= rsi_sat32(s10_q_in[i]);
         end
         s10_t0s_ff <= rsi_sat32($signed({{16{s9_t0_ff[50]}}, s9_t0_ff}));
         s10_c_ff   <= s9_c_ff;
      end
   end

   // ---------------- stage 11: n = point - centre
   logic               s11_vld_ff;
   logic               s11_miss_ff;
   logic signed [32:0] s11_n_in [3];
   logic signed [32:0] s11_n_ff [3];
   logic signed [31:0] s11_p_ff [3];
   logic signed [31:0] s11_t0s_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s11_n_in[i] = $signed({s10_p_ff[i][31], s10_p_ff[i]})
                     - $signed({s10_c_ff[i][31], s10_c_ff[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_vld_ff <= 1'b0;
      end else if (adv) begin
         s11_vld_ff <= s10_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s11_miss_ff <= s10_miss_ff;
         s11_n_ff    <= s11_n_in;
         s11_p_ff    <= s10_p_ff;
         s11_t0s_ff  <= s10_t0s_ff;
      end
   end

   // ---------------- stage 12: n squared
   logic               s12_vld_ff;
   logic               s12_miss_ff;
   logic signed [64:0] s12_nsq_in [3];
   logic [64:0]        s12_nsq_ff [3];
   logic signed [32:0] s12_n_ff [3];
   logic signed [31:0] s12_p_ff [3];
   logic signed [31:0] s12_t0s_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s12_nsq_in[i] = $signed({{32{s11_n_ff[i][32]}}, s11_n_ff[i]})
                       * $signed({{32{s11_n_ff[i][32]}}, s11_n_ff[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s12_vld_ff <= 1'b0;
      end else if (adv) begin
         s12_vld_ff <= s11_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s12_miss_ff <= s11_miss_ff;
         for (int i = 0; i < 3; i++) begin
            s12_nsq_ff[i] <= s12_nsq_in[i];
         end
         s12_n_ff   <= s11_n_ff;
         s12_p_ff   <= s11_p_ff;
         s12_t0s_ff <= s11_t0s_ff;
      end
   end

   // ---------------- stage 13: n.n
   logic               s13_vld_ff;
   logic               s13_miss_ff;
   logic [NN_W-1:0]    s13_nn_ff;
   logic signed [32:0] s13_n_ff [3];
   logic signed [31:0] s13_p_ff [3];
   logic signed [31:0] s13_t0s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s13_vld_ff <= 1'b0;
      end else if (adv) begin
         s13_vld_ff <= s12_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s13_miss_ff <= s12_miss_ff;
         s13_nn_ff   <= {1'b0, s12_nsq_ff[0]} + {1'b0, s12_nsq_ff[1]} + {1'b0, s12_nsq_ff[2]};
         s13_n_ff    <= s12_n_ff;
         s13_p_ff    <= s12_p_ff;
         s13_t0s_ff  <= s12_t0s_ff;
      end
   end

   // ---------------- normal length = floor(sqrt(n.n))
   logic               q2_vld;
   logic [LEN_W-1:0]   q2_len;
   logic [SIDE2_W-1:0] q2_side;
   logic               q2_miss;
   logic signed [31:0] q2_t0s;
   logic signed [31:0] q2_p [3];
   logic signed [32:0] q2_n [3];

   rsi_sqrt #(
      .IN_W   (NN_W),
      .SIDE_W (SIDE2_W)
   ) u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s13_vld_ff),
      .in_rad    (s13_nn_ff),
      .in_side   ({s13_miss_ff, s13_t0s_ff,
                   s13_p_ff[0], s13_p_ff[1], s13_p_ff[2],
                   s13_n_ff[0], s13_n_ff[1], s13_n_ff[2]}),
      .out_valid (q2_vld),
      .out_root  (q2_len),
      .out_side  (q2_side)
   );

   assign {q2_miss, q2_t0s, q2_p[0], q2_p[1], q2_p[2], q2_n[0], q2_n[1], q2_n[2]} = q2_side;

   // ---------------- stage 14: magnitudes and signs for the normal division
   logic               s14_vld_ff;
   logic               s14_miss_ff;
   logic               s14_lenz_ff;
   logic [LEN_W-1:0]   s14_len_ff;
   logic [32:0]        s14_mag_in [3];
   logic [NUM_W-1:0]   s14_num_ff [3];
   logic               s14_neg_ff [3];
   logic signed [31:0] s14_p_ff [3];
   logic signed [31:0] s14_t0s_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s14_mag_in[i] = q2_n[i][32] ? 33'(-q2_n[i]) : 33'(q2_n[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s14_vld_ff <= 1'b0;
      end else if (adv) begin
         s14_vld_ff <= q2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s14_miss_ff <= q2_miss;
         s14_lenz_ff <= (q2_len == '0);
         s14_len_ff  <= q2_len;
         for (int i = 0; i < 3; i++) begin
            s14_num_ff[i] <= {s14_mag_in[i], 16'b0};
            s14_neg_ff[i] <= q2_n[i][32];
         end
         s14_p_ff   <= q2_p;
         s14_t0s_ff <= q2_t0s;
      end
   end

   // ---------------- normal components |n|*65536 / len, one divider per axis
   logic                dv_vld [3];
   logic [NUM_W-1:0]    dv_quo [3];
   logic [DSIDE0_W-1:0] dv0_side;
   logic                dv1_neg;
   logic                dv2_neg;
   logic                f_neg0;
   logic                f_miss;
   logic                f_lenz;
   logic signed [31:0]  f_t0s;
   logic signed [31:0]  f_p [3];

   rsi_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (LEN_W),
      .SIDE_W (DSIDE0_W)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s14_vld_ff),
      .in_num    (s14_num_ff[0]),
      .in_den    (s14_len_ff),
      .in_side   ({s14_neg_ff[0], s14_miss_ff, s14_lenz_ff, s14_t0s_ff,
                   s14_p_ff[0], s14_p_ff[1], s14_p_ff[2]}),
      .out_valid (dv_vld[0]),
      .out_quo   (dv_quo[0]),
      .out_side  (dv0_side)
   );

   rsi_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (LEN_W),
      .SIDE_W (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s14_vld_ff),
      .in_num    (s14_num_ff[1]),
      .in_den    (s14_len_ff),
      .in_side   (s14_neg_ff[1]),
      .out_valid (dv_vld[1]),
      .out_quo   (dv_quo[1]),
      .out_side  (dv1_neg)
   );

   rsi_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (LEN_W),
      .SIDE_W (1)
   ) u_div_z (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s14_vld_ff),
      .in_num    (s14_num_ff[2]),
      .in_den    (s14_len_ff),
      .in_side   (s14_neg_ff[2]),
      .out_valid (dv_vld[2]),
      .out_quo   (dv_quo[2]),
      .out_side  (dv2_neg)
   );

   assign {f_neg0, f_miss, f_lenz, f_t0s, f_p[0], f_p[1], f_p[2]} = dv0_side;

   // Apply the sign and clamp a quotient magnitude to signed 32 bits
   function automatic logic signed [31:0] norm_sat(logic neg, logic [NUM_W-1:0] q);
      logic [NUM_W-1:0] nq;
      nq = -q;
      if (neg) begin
         return (q > NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000 : nq[31:0];
      end
      return (q > NUM_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
   endfunction

   // ---------------- output register: zero everything on a miss, the normal on a zero length
   always_comb begin
      rsp_in = '0;
      if (!f_miss) begin
         rsp_in.hit          = 1'b1;
         rsp_in.hit_distance = f_t0s;
         rsp_in.point_x      = f_p[0];
         rsp_in.point_y      = f_p[1];
         rsp_in.point_z      = f_p[2];
         if (!f_lenz) begin
            rsp_in.normal_x = norm_sat(f_neg0, dv_quo[0]);
            rsp_in.normal_y = norm_sat(dv1_neg, dv_quo[1]);
            rsp_in.normal_z = norm_sat(dv2_neg, dv_quo[2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_vld[0] & dv_vld[1] & dv_vld[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/rsi_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined floor square root, one result bit per stage.
module rsi_sqrt #(
   parameter int IN_W   = 100,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [IN_W-1:0]     in_rad,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [IN_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int ROOT_W = IN_W / 2;

   logic              vld_ff  [ROOT_W];
   logic [IN_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic              vld_p;
      logic [IN_W-1:0]   rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [SIDE_W-1:0] side_p;
      logic [IN_W:0]     trial;
      logic [IN_W-1:0]   rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign vld_p  = in_valid;
         assign rem_p  = in_rad;
         assign root_p = '0;
         assign side_p = in_side;
      end else begin : g_next
         assign vld_p  = vld_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      // try setting this bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
      assign trial = ((IN_W+1)'(root_p) << (B + 1)) + ((IN_W+1)'(1) << (2 * B));

      always_comb begin
         rem_in  = rem_p;
         root_in = root_p;
         if ({1'b0, rem_p} >= trial) begin
            rem_in  = rem_p - trial[IN_W-1:0];
            root_in = root_p | (ROOT_W'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ===== hw/rtl/rsi_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring unsigned divider, one quotient bit per stage.
module rsi_div #(
   parameter int NUM_W  = 49,
   parameter int DEN_W  = 33,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [NUM_W-1:0]    in_num,
   input  logic [DEN_W-1:0]    in_den,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [NUM_W-1:0]    out_quo,
   output logic [SIDE_W-1:0]   out_side
);
   logic              vld_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [NUM_W-1:0]  quo_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      localparam int B = NUM_W - 1 - k;
      logic              vld_p;
      logic [DEN_W-1:0]  rem_p;
      logic [NUM_W-1:0]  num_p;
      logic [DEN_W-1:0]  den_p;
      logic [NUM_W-1:0]  quo_p;
      logic [SIDE_W-1:0] side_p;
      logic [DEN_W:0]    shifted;
      logic [DEN_W:0]    diff;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  quo_in;

      if (k == 0) begin : g_first
         assign vld_p  = in_valid;
         assign rem_p  = '0;
         assign num_p  = in_num;
         assign den_p  = in_den;
         assign quo_p  = '0;
         assign side_p = in_side;
      end else begin : g_next
         assign vld_p  = vld_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign num_p  = num_ff[k-1];
         assign den_p  = den_ff[k-1];
         assign quo_p  = quo_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      // bring down the next dividend bit and subtract when it fits
      assign shifted = {rem_p, num_p[B]};
      assign diff    = shifted - {1'b0, den_p};

      always_comb begin
         rem_in = shifted[DEN_W-1:0];
         quo_in = quo_p;
         if (shifted >= {1'b0, den_p}) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = quo_p | (NUM_W'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            num_ff[k]  <= num_p;
            den_ff[k]  <= den_p;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule
